@@ hw/rtl/fcs_pkg.sv @@
// ----------------------------------------------------------------------------
// fcs_pkg
// shared types, constants and helpers of the fast corner score unit
// ----------------------------------------------------------------------------
package fcs_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int WINDOW_LINES = 6;
    localparam int WIN          = WINDOW_LINES + 1;
    localparam int PIX_W        = 8;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = 12;
    localparam int IWIDTH_W     = 12;
    localparam int SCORE_W      = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int RING_N       = 16;
    localparam int RING_S       = 8;
    localparam int QUART_L      = RING_N / 4;
    localparam int QUART_S      = RING_S / 4;
    localparam int CNT_W        = $clog2(RING_N + 1);

    localparam int CTR_L        = 3;
    localparam int OFF_S        = 4;
    localparam int CTR_S        = OFF_S + 1;

    localparam logic [ROW_W-1:0]    ROW_MAX      = {ROW_W{1'b1}};
    localparam logic [PIX_W-1:0]    THRESH_RESET = PIX_W'(50);
    localparam logic [IWIDTH_W-1:0] WIDTH_RESET  = IWIDTH_W'(1024);
    localparam logic [IWIDTH_W-1:0] WIDTH_MAX    = IWIDTH_W'(MAX_WIDTH);
    localparam logic [IWIDTH_W-1:0] WIDTH_MIN    = IWIDTH_W'(1);
    localparam logic [ROW_W-1:0]    EDGE_L       = ROW_W'(2 * CTR_L);
    localparam logic [ROW_W-1:0]    EDGE_S       = ROW_W'(2);
    localparam logic [CNT_W-1:0]    NEED_L       = CNT_W'(9);
    localparam logic [CNT_W-1:0]    NEED_S       = CNT_W'(5);
    localparam logic [2:0]          CARD_NEED    = 3'd3;

    localparam logic [2:0] RING16_R [RING_N] =
        '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
          3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
    localparam logic [2:0] RING16_C [RING_N] =
        '{3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4,
          3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2};
    localparam logic [2:0] RING8_R [RING_S] =
        '{3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd2, 3'd1, 3'd0};
    localparam logic [2:0] RING8_C [RING_S] =
        '{3'd1, 3'd2, 3'd2, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_MODE      = 2'd1,
        CFG_WIDTH     = 2'd2
    } fcs_cfg_idx_t;

    typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] fcs_win_t;
    typedef logic [WIN-1:0][PIX_W-1:0]          fcs_col_t;
    typedef logic [WINDOW_LINES-1:0][PIX_W-1:0] fcs_lines_t;
    typedef logic [RING_N-1:0][PIX_W-1:0]       fcs_ring_t;

    typedef struct packed {
        logic [PIX_W-1:0] threshold;
        logic             narrow;
    } fcs_cfg_t;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] pixel;
    } fcs_lwr_t;

    function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ hw/rtl/fcs_line_store.sv @@
// ----------------------------------------------------------------------------
// fcs_line_store
// per-column store of the previous rows, one read and one write per cycle
// ----------------------------------------------------------------------------
module fcs_line_store (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [fcs_pkg::COL_W-1:0] rd_addr,
    input  fcs_pkg::fcs_lwr_t        wr,
    output fcs_pkg::fcs_lines_t      lines
);
    import fcs_pkg::*;

    fcs_lines_t mem [MAX_WIDTH];
    fcs_lines_t rd_data_reg;
    fcs_lines_t fwd_data_reg;
    logic       fwd_reg;
    fcs_lines_t wr_data;

    // each row moves one line older, the new pixel enters the newest line
    assign wr_data = {lines[WINDOW_LINES-2:0], wr.pixel};
    assign lines   = fwd_reg ? fwd_data_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // same column read while it is being written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

endmodule

@@ hw/rtl/fcs_window.sv @@
// ----------------------------------------------------------------------------
// fcs_window
// 7x7 pixel window that shifts in one column per word
// ----------------------------------------------------------------------------
module fcs_window (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  fcs_pkg::fcs_col_t col_in,
    output fcs_pkg::fcs_win_t win_reg
);
    import fcs_pkg::*;

    fcs_win_t win_next;

    always_comb
    begin
        for (int r = 0; r < WIN; r++)
        begin
            for (int k = 0; k < WIN - 1; k++)
            begin
                win_next[r][k] = win_reg[r][k+1];
            end
            win_next[r][WIN-1] = col_in[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (en)
        begin
            win_reg <= win_next;
        end
    end

endmodule

@@ hw/rtl/fcs_ring_diff.sv @@
// ----------------------------------------------------------------------------
// fcs_ring_diff
// absolute differences and threshold tests of the circle points
// ----------------------------------------------------------------------------
module fcs_ring_diff (
    input  logic                       clk,
    input  logic                       en,
    input  fcs_pkg::fcs_win_t          win,
    input  fcs_pkg::fcs_cfg_t          cfg,
    input  logic                       full,
    output fcs_pkg::fcs_ring_t         diff_reg,
    output logic [fcs_pkg::RING_N-1:0] pass_reg
);
    import fcs_pkg::*;

    logic [PIX_W-1:0]  center;
    fcs_ring_t         pt_l;
    fcs_ring_t         pt;
    logic [RING_N-1:0] used;
    fcs_ring_t         diff_next;
    logic [RING_N-1:0] pass_next;

    always_comb
    begin
        center = cfg.narrow ? win[CTR_S][CTR_S] : win[CTR_L][CTR_L];
        for (int i = 0; i < RING_N; i++)
        begin
            pt_l[i] = win[RING16_R[i]][RING16_C[i]];
        end
        pt   = pt_l;
        used = '1;
        if (cfg.narrow)
        begin
            pt   = '0;
            used = '0;
            for (int i = 0; i < RING_S; i++)
            begin
                pt[i]   = win[OFF_S + int'(RING8_R[i])][OFF_S + int'(RING8_C[i])];
                used[i] = 1'b1;
            end
        end
        for (int i = 0; i < RING_N; i++)
        begin
            diff_next[i] = used[i] ? absdiff(center, pt[i]) : '0;
            pass_next[i] = full && used[i] && (diff_next[i] > cfg.threshold);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            pass_reg <= pass_next;
        end
    end

endmodule

@@ hw/rtl/fcs_score.sv @@
// ----------------------------------------------------------------------------
// fcs_score
// corner decision and circle difference sum into the result register
// ----------------------------------------------------------------------------
module fcs_score (
    input  logic                        clk,
    input  logic                        en,
    input  fcs_pkg::fcs_ring_t          diff,
    input  logic [fcs_pkg::RING_N-1:0]  pass,
    input  fcs_pkg::fcs_cfg_t           cfg,
    output logic [fcs_pkg::SCORE_W-1:0] score_reg,
    output logic                        corner_reg
);
    import fcs_pkg::*;

    logic [PIX_W:0]     sum1 [RING_N/2];
    logic [PIX_W+1:0]   sum2 [RING_N/4];
    logic [PIX_W+2:0]   sum3 [RING_N/8];
    logic [SCORE_W-1:0] sum;
    logic [CNT_W-1:0]   total;
    logic [1:0]         pair;
    logic [2:0]         card;
    logic [CNT_W-1:0]   need;
    logic               corner;

    always_comb
    begin
        for (int i = 0; i < RING_N / 2; i++)
        begin
            sum1[i] = {1'b0, diff[2*i]} + {1'b0, diff[2*i+1]};
        end
        for (int i = 0; i < RING_N / 4; i++)
        begin
            sum2[i] = {1'b0, sum1[2*i]} + {1'b0, sum1[2*i+1]};
        end
        for (int i = 0; i < RING_N / 8; i++)
        begin
            sum3[i] = {1'b0, sum2[2*i]} + {1'b0, sum2[2*i+1]};
        end
        sum   = {1'b0, sum3[0]} + {1'b0, sum3[1]};
        total = CNT_W'($countones(pass));
        if (cfg.narrow)
        begin
            pair = {1'b0, pass[0]} + {1'b0, pass[2*QUART_S]};
            card = {1'b0, pair} + {2'b0, pass[QUART_S]} + {2'b0, pass[3*QUART_S]};
            need = NEED_S;
        end
        else
        begin
            pair = {1'b0, pass[0]} + {1'b0, pass[2*QUART_L]};
            card = {1'b0, pair} + {2'b0, pass[QUART_L]} + {2'b0, pass[3*QUART_L]};
            need = NEED_L;
        end
        corner = (pair != 2'd0) && (card >= CARD_NEED) && (total >= need);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            score_reg  <= corner ? sum : '0;
            corner_reg <= corner;
        end
    end

endmodule

@@ hw/rtl/fast_corner_score_unit.sv @@
// ----------------------------------------------------------------------------
// fast_corner_score_unit
// streaming corner scorer over a 7x7 or 3x3 window of 8-bit gray pixels
// ----------------------------------------------------------------------------
// One pixel word is taken every clock while pix_stall is low, and one score
// word comes out for each, in order, through the line read, window shift,
// circle difference and score registers. The rate is set by the line store,
// a single 2048 x 48-bit memory with one read and one write per cycle; a new
// pixel reads its column while the pixel before it writes back, with
// forwarding when both hit the same column. Four pipeline stages (line read,
// window shift, circle differences, score) each hold one word, so the unit
// holds up to four pixels in flight and stalls its input only when all four
// stages are full and the result is not taken. Configuration writes are
// accepted every cycle and must only be made while the pipeline is empty.
// ----------------------------------------------------------------------------
module fast_corner_score_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  logic [fcs_pkg::PIX_W-1:0]      pixel,
    input  logic                           frame_start,
    output logic                           score_valid,
    input  logic                           score_stall,
    output logic [fcs_pkg::SCORE_W-1:0]    corner_score,
    output logic                           is_corner,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fcs_pkg::*;

    logic [PIX_W-1:0]    threshold_reg;
    logic                small_reg;
    logic [IWIDTH_W-1:0] image_width_reg;
    fcs_cfg_t            cfg;

    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_cur;
    logic [ROW_W-1:0]    row_cur;
    logic [IWIDTH_W-1:0] width_used;
    logic [IWIDTH_W-1:0] col_inc;
    logic [ROW_W-1:0]    edge_min;
    logic                full_cur;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic score_valid_reg, score_valid_next;
    logic out_ready, s3_ready, s2_ready, s1_ready;
    logic accept, mv1, mv2, mv3;

    logic [PIX_W-1:0] s1_pixel_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_full_reg;
    logic             s2_full_reg;

    fcs_lwr_t          lwr;
    fcs_lines_t        lines;
    fcs_col_t          col_in;
    fcs_win_t          win;
    fcs_ring_t         diff;
    logic [RING_N-1:0] pass;

    assign cfg       = '{threshold: threshold_reg, narrow: small_reg};
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESH_RESET;
            small_reg       <= 1'b0;
            image_width_reg <= WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: threshold_reg   <= cfg_data[PIX_W-1:0];
                CFG_MODE:      small_reg       <= cfg_data[0];
                CFG_WIDTH:     image_width_reg <= cfg_data[IWIDTH_W-1:0];
                default:       ;
            endcase
        end
    end

    // handshake and stage advance
    assign out_ready = !score_valid_reg || !score_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pix_stall = !s1_ready;
    assign accept    = pix_valid && s1_ready;
    assign mv1       = s1_valid_reg && s2_ready;
    assign mv2       = s2_valid_reg && s3_ready;
    assign mv3       = s3_valid_reg && out_ready;

    always_comb
    begin
        s1_valid_next    = accept || (s1_valid_reg && !s2_ready);
        s2_valid_next    = mv1 || (s2_valid_reg && !s3_ready);
        s3_valid_next    = mv2 || (s3_valid_reg && !out_ready);
        score_valid_next = mv3 || (score_valid_reg && score_stall);
    end

    // position counters
    always_comb
    begin
        col_cur = frame_start ? '0 : col_reg;
        row_cur = frame_start ? '0 : row_reg;
        if (image_width_reg < WIDTH_MIN)
        begin
            width_used = WIDTH_MIN;
        end
        else if (image_width_reg > WIDTH_MAX)
        begin
            width_used = WIDTH_MAX;
        end
        else
        begin
            width_used = image_width_reg;
        end
        col_inc  = IWIDTH_W'(col_cur) + IWIDTH_W'(1);
        edge_min = small_reg ? EDGE_S : EDGE_L;
        full_cur = (row_cur >= edge_min) && (ROW_W'(col_cur) >= edge_min);
        if (col_inc >= width_used)
        begin
            col_next = '0;
            row_next = (row_cur < ROW_MAX) ? row_cur + ROW_W'(1) : row_cur;
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            score_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg    <= s1_valid_next;
            s2_valid_reg    <= s2_valid_next;
            s3_valid_reg    <= s3_valid_next;
            score_valid_reg <= score_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_cur;
            s1_full_reg  <= full_cur;
        end
        if (mv1)
        begin
            s2_full_reg <= s1_full_reg;
        end
    end

    // oldest line at the top of the window, the new pixel at the bottom
    always_comb
    begin
        for (int r = 0; r < WINDOW_LINES; r++)
        begin
            col_in[r] = lines[WINDOW_LINES-1-r];
        end
        col_in[WIN-1] = s1_pixel_reg;
    end

    assign lwr = '{en: mv1, addr: s1_col_reg, pixel: s1_pixel_reg};

    fcs_line_store u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .wr      (lwr),
        .lines   (lines)
    );

    fcs_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (mv1),
        .col_in  (col_in),
        .win_reg (win)
    );

    fcs_ring_diff u_ring_diff (
        .clk      (clk),
        .en       (mv2),
        .win      (win),
        .cfg      (cfg),
        .full     (s2_full_reg),
        .diff_reg (diff),
        .pass_reg (pass)
    );

    fcs_score u_score (
        .clk        (clk),
        .en         (mv3),
        .diff       (diff),
        .pass       (pass),
        .cfg        (cfg),
        .score_reg  (corner_score),
        .corner_reg (is_corner)
    );

    assign score_valid = score_valid_reg;

`ifndef NO_ASSERTIONS
    a_score_zero_no_corner: assert property (@(posedge clk) disable iff (!rst_n)
        score_valid && !is_corner |-> corner_score == '0)
        else $error("score set on a non-corner");

    a_score_nonzero_corner: assert property (@(posedge clk) disable iff (!rst_n)
        score_valid && is_corner |-> corner_score != '0)
        else $error("corner with zero score");

    a_frame_start_col: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_start |=> col_reg == COL_W'(1) || col_reg == '0)
        else $error("column not restarted at frame start");
`endif

endmodule
